### hdl/shs_pkg.sv
// Package for the streaming SHA-256 hasher: round constants, initial hash value
// and the SHA-256 word functions. No dependencies.

package shs_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 512;
    localparam int CHAIN_W = 256;
    localparam int ROUNDS  = 64;

    // Initial hash value, word 0 in the top bits
    localparam logic [CHAIN_W-1:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PAD   = 4'b0010,
        S_ROUND = 4'b0100,
        S_ADD   = 4'b1000
    } state_t;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

### hdl/sha256_stream_hasher_unit.sv
// Streaming SHA-256 hasher: byte input stream, 64-bit digest output stream.
// Depends on shs_pkg for round constants, initial hash and word functions.

// Each message byte is one input transaction, accepted while the unit is
// idle. Every 64th byte starts a compression of 64 rounds on a single shared
// round unit, followed by a fold of the result into the chaining state, during
// which s_tready is low, so no byte is taken while a block is compressed.
// The transaction with s_tlast set then feeds padding and the length one
// byte per cycle into the block (one block, or two when the length does not
// fit), each closed by a compression. The digest leaves as four
// 64-bit transactions, most significant first, from an output register; the
// next message can start streaming in while they wait to be taken, but its
// closing fold holds until the last part of the previous digest has gone.

module sha256_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_part
    output logic [1:0]  m_tuser,   // [1:0] part_index
    output logic        m_tlast    // digest_last
);

    localparam int NWORDS = shs_pkg::CHAIN_W / shs_pkg::WORD_W;

    shs_pkg::state_t state_reg, state_next;

    logic [5:0]                   cnt_reg, cnt_next;
    logic [63:0]                  bits_reg, bits_next;
    logic [5:0]                   rnd_reg, rnd_next;
    logic                         pad_act_reg, pad_act_next;
    logic                         first_reg, first_next;
    logic                         len_ok_reg, len_ok_next;
    logic                         fin_reg, fin_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   part_reg, part_next;
    shs_pkg::word_t               chain_reg [NWORDS];
    shs_pkg::word_t               chain_next [NWORDS];
    shs_pkg::word_t               wv_reg [NWORDS];
    shs_pkg::word_t               wv_next [NWORDS];
    logic [shs_pkg::BLOCK_W-1:0]  blk_reg, blk_next;
    logic [shs_pkg::CHAIN_W-1:0]  out_buf_reg, out_buf_next;

    logic                         start_comp;
    logic [5:0]                   cnt_after;
    logic [7:0]                   pad_byte;
    shs_pkg::word_t               t1, t2, w_new;
    shs_pkg::word_t               sums [NWORDS];

    assign s_tready = (state_reg == shs_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_buf_reg[shs_pkg::CHAIN_W-1 -: 64];
    assign m_tuser  = part_reg;
    assign m_tlast  = (part_reg == 2'd3);

    // Round unit: the window holds w[t] .. w[t+15], w[t] in the top word
    always_comb
    begin
        t1 = wv_reg[7] + shs_pkg::big_sigma1(wv_reg[4])
           + shs_pkg::choose(wv_reg[4], wv_reg[5], wv_reg[6])
           + shs_pkg::round_k(rnd_reg) + blk_reg[511:480];
        t2 = shs_pkg::big_sigma0(wv_reg[0])
           + shs_pkg::majority(wv_reg[0], wv_reg[1], wv_reg[2]);
        w_new = blk_reg[511:480] + shs_pkg::small_sigma0(blk_reg[479:448])
              + blk_reg[223:192] + shs_pkg::small_sigma1(blk_reg[63:32]);
        for (int i = 0; i < NWORDS; i++)
        begin
            sums[i] = chain_reg[i] + wv_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        rnd_next       = rnd_reg;
        pad_act_next   = pad_act_reg;
        first_next     = first_reg;
        len_ok_next    = len_ok_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        part_next      = part_reg;
        chain_next     = chain_reg;
        wv_next        = wv_reg;
        blk_next       = blk_reg;
        out_buf_next   = out_buf_reg;
        start_comp     = 1'b0;
        cnt_after      = cnt_reg + {5'b0, s_tuser};
        pad_byte       = 8'h00;

        // Drain the digest one part per output transaction
        if (out_valid_reg && m_tready)
        begin
            out_buf_next = {out_buf_reg[shs_pkg::CHAIN_W-65:0], 64'b0};
            part_next    = part_reg + 2'd1;
            if (part_reg == 2'd3)
            begin
                out_valid_next = 1'b0;
            end
        end

        case (state_reg)
            shs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        blk_next  = {blk_reg[shs_pkg::BLOCK_W-9:0], s_tdata};
                        cnt_next  = cnt_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tlast)
                    begin
                        pad_act_next = 1'b1;
                        first_next   = 1'b1;
                        len_ok_next  = (cnt_after <= 6'd55);
                    end
                    if (s_tuser && cnt_reg == 6'd63)
                    begin
                        start_comp = 1'b1;
                    end
                    else if (s_tlast)
                    begin
                        state_next = shs_pkg::S_PAD;
                    end
                end
            end
            shs_pkg::S_PAD:
            begin
                if (first_reg)
                begin
                    pad_byte = shs_pkg::PAD_MARK;
                end
                else if (len_ok_reg && cnt_reg >= 6'd56)
                begin
                    // Length goes out big-endian: take the top byte and advance
                    pad_byte  = bits_reg[63:56];
                    bits_next = {bits_reg[55:0], 8'h00};
                end
                first_next = 1'b0;
                blk_next   = {blk_reg[shs_pkg::BLOCK_W-9:0], pad_byte};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    start_comp = 1'b1;
                    fin_next   = len_ok_reg;
                end
            end
            shs_pkg::S_ROUND:
            begin
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                blk_next   = {blk_reg[shs_pkg::BLOCK_W-33:0], w_new};
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'(shs_pkg::ROUNDS - 1))
                begin
                    state_next = shs_pkg::S_ADD;
                end
            end
            shs_pkg::S_ADD:
            begin
                // Hold the final fold until the previous digest has gone
                if (!(fin_reg && out_valid_reg))
                begin
                    if (fin_reg)
                    begin
                        for (int i = 0; i < NWORDS; i++)
                        begin
                            out_buf_next[shs_pkg::CHAIN_W-1-32*i -: 32] = sums[i];
                            chain_next[i] =
                                shs_pkg::INIT_HASH[shs_pkg::CHAIN_W-1-32*i -: 32];
                        end
                        out_valid_next = 1'b1;
                        part_next      = 2'd0;
                        bits_next      = 64'd0;
                        cnt_next       = 6'd0;
                        pad_act_next   = 1'b0;
                        first_next     = 1'b0;
                        len_ok_next    = 1'b0;
                        fin_next       = 1'b0;
                        state_next     = shs_pkg::S_IDLE;
                    end
                    else
                    begin
                        chain_next = sums;
                        if (pad_act_reg)
                        begin
                            len_ok_next = 1'b1;
                            state_next  = shs_pkg::S_PAD;
                        end
                        else
                        begin
                            state_next = shs_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = shs_pkg::S_IDLE;
            end
        endcase

        if (start_comp)
        begin
            wv_next    = chain_reg;
            rnd_next   = 6'd0;
            state_next = shs_pkg::S_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shs_pkg::S_IDLE;
            cnt_reg       <= 6'd0;
            bits_reg      <= 64'd0;
            rnd_reg       <= 6'd0;
            pad_act_reg   <= 1'b0;
            first_reg     <= 1'b0;
            len_ok_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            part_reg      <= 2'd0;
            for (int i = 0; i < NWORDS; i++)
            begin
                chain_reg[i] <= shs_pkg::INIT_HASH[shs_pkg::CHAIN_W-1-32*i -: 32];
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bits_reg      <= bits_next;
            rnd_reg       <= rnd_next;
            pad_act_reg   <= pad_act_next;
            first_reg     <= first_next;
            len_ok_reg    <= len_ok_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            part_reg      <= part_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg      <= wv_next;
        blk_reg     <= blk_next;
        out_buf_reg <= out_buf_next;
    end

    a_fin_implies_len : assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (len_ok_reg && pad_act_reg))
        else $error("final block flagged without length in place");

    a_pad_active : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shs_pkg::S_PAD) |-> pad_act_reg)
        else $error("padding without an ending transaction");

    a_last_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg != shs_pkg::S_IDLE))
        else $error("ending transaction did not start padding");

    a_digest_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("digest reloaded over an unsent part");

    a_round_entry : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == shs_pkg::S_ROUND) |-> (rnd_reg == 6'd0))
        else $error("compression started mid-count");

endmodule

### tb/testbench.sv
// Self-checking bench for sha256_stream_hasher_unit: byte messages in, digest parts out.
// Needs shs_pkg for the word type only; the digest predictor below is self-contained.

module testbench;

    typedef shs_pkg::word_t word_t;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 300;

    typedef struct {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        digest_last;
    } digest_word_t;

    class digest_scoreboard;
        word_t        hash_words[8];
        logic [63:0]  bit_count;
        logic [7:0]   block_buf[64];
        int unsigned  fill;
        int unsigned  errors;
        digest_word_t pending_parts[$];

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            hash_words = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            bit_count = '0;
            fill = 0;
        endfunction

        function word_t rotr(word_t x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function word_t round_const(int unsigned i);
            word_t k_tab[64];
            k_tab = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k_tab[i];
        endfunction

        function void compress_block();
            word_t w[64];
            word_t s[8];
            word_t t1;
            word_t t2;
            for (int i = 0; i < 16; i++)
                w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
            s = hash_words;
            for (int i = 0; i < 64; i++)
            begin
                t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
                   + ((s[4] & s[5]) ^ (~s[4] & s[6])) + round_const(i) + w[i];
                t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
                   + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
                s[7] = s[6];
                s[6] = s[5];
                s[5] = s[4];
                s[4] = s[3] + t1;
                s[3] = s[2];
                s[2] = s[1];
                s[1] = s[0];
                s[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_words[i] = hash_words[i] + s[i];
        endfunction

        // Note one accepted input transaction; an ending one queues four digest parts
        function void absorb(logic [7:0] data, logic valid, logic ending);
            int unsigned pos;
            digest_word_t part;
            if (valid)
            begin
                block_buf[fill] = data;
                fill++;
                bit_count = bit_count + 64'd8;
                if (fill == 64)
                begin
                    compress_block();
                    fill = 0;
                end
            end
            if (!ending)
                return;
            pos = fill;
            block_buf[pos] = 8'h80;
            pos++;
            // no room for the length: close this block and pad a second one
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_buf[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                block_buf[56+i] = bit_count[8*(7-i) +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                part.digest_part = {hash_words[2*k], hash_words[2*k+1]};
                part.part_index  = k[1:0];
                part.digest_last = (k == 3);
                pending_parts.push_back(part);
            end
            restart();
        endfunction

        function void check_part(logic [63:0] data, logic [1:0] idx, logic last);
            digest_word_t want;
            if (pending_parts.size() == 0)
            begin
                $error("digest transaction with none expected: %h", data);
                errors++;
                return;
            end
            want = pending_parts.pop_front();
            if (data !== want.digest_part)
            begin
                $error("digest_part: expected %h, got %h", want.digest_part, data);
                errors++;
            end
            if (idx !== want.part_index)
            begin
                $error("part_index: expected %0d, got %0d", want.part_index, idx);
                errors++;
            end
            if (last !== want.digest_last)
            begin
                $error("digest_last: expected %0d, got %0d", want.digest_last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_parts.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    digest_scoreboard sb;
    bit               calm_phase;
    int unsigned      items_sent;
    int unsigned      messages_done;
    int unsigned      cycle_count;

    sha256_stream_hasher_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sha256_stream_hasher_unit: mismatch");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Digest side: check each transaction, then stall at random
    initial
    begin
        int unsigned hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_part(m_tdata, m_tuser, m_tlast);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_item(input logic [7:0] data, input logic valid, input logic ending);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= ending;
        do
            @(posedge clk);
        while (!s_tready);
        sb.absorb(data, valid, ending);
        if (valid || ending)
            items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the input until every queued digest part has been taken
    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int unsigned len, input bit end_on_byte);
        for (int unsigned i = 0; i < len; i++)
        begin
            // drop in an idle transaction now and then
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (len == 0 || !end_on_byte)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_done++;
    endtask

    initial
    begin
        int unsigned boundary_lengths[8];
        int unsigned len;
        boundary_lengths = '{55, 56, 57, 63, 64, 65, 119, 120};
        sb = new();
        items_sent    = 0;
        messages_done = 0;
        calm_phase    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message straight after reset
        send_item(8'hff, 1'b0, 1'b1);
        // idle transaction, then a byte carrying the end
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_for_digests();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);
        wait_for_digests();

        // padding into a second block, then a full block before the tail
        send_message(56, 1'b1);
        send_message(64, 1'b0);

        while (items_sent < 150 || messages_done < 4)
        begin
            if ($urandom_range(0, 99) < 10)
                len = boundary_lengths[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 9);
            if ($urandom_range(0, 5) == 0)
                calm_phase = !calm_phase;
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
                wait_for_digests();
        end

        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sha256_stream_hasher_unit: match");
        else
            $display("sha256_stream_hasher_unit: mismatch");
        $finish;
    end

endmodule
